### design/lr_pkg.sv
// shared types and constants for the line rasterizer
// no dependencies; used by every design file of the block

package lr_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // opcode of an input word
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DRAW = 2'd1
  } lr_phase_t;

  // line set up along its major axis
  typedef struct packed {
    logic [COORD_BITS-1:0]        major_pos;
    logic [COORD_BITS-1:0]        minor_pos;
    logic [COORD_BITS-1:0]        major_stop;
    logic [DELTA_BITS-1:0]        major_delta;
    logic signed [DELTA_BITS-1:0] minor_delta;
    logic                         x_is_major;
  } lr_line_t;

  // outcome of one step along the line
  typedef struct packed {
    logic                       done;
    logic [COORD_BITS-1:0]      major_pos;
    logic [COORD_BITS-1:0]      minor_pos;
    logic signed [ERR_BITS-1:0] error_term;
  } lr_step_t;

endpackage

### design/lr_setup.sv
// line setup: deltas, major axis choice and endpoint ordering
// depends on lr_pkg

module lr_setup (
  input  logic [lr_pkg::COORD_BITS-1:0] x_start,
  input  logic [lr_pkg::COORD_BITS-1:0] y_start,
  input  logic [lr_pkg::COORD_BITS-1:0] x_end,
  input  logic [lr_pkg::COORD_BITS-1:0] y_end,
  output lr_pkg::lr_line_t              line
);

  logic signed [lr_pkg::DELTA_BITS-1:0] dx, dy, adx, ady, dma, dmi;
  logic                                 x_major;
  logic [lr_pkg::COORD_BITS-1:0]        ma0, mi0, ma1;

  always_comb begin
    dx = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx = dx[lr_pkg::DELTA_BITS-1] ? -dx : dx;
    ady = dy[lr_pkg::DELTA_BITS-1] ? -dy : dy;
    // equal spans count as x-major
    x_major = (adx >= ady);
    if (x_major) begin
      ma0 = x_start; mi0 = y_start; ma1 = x_end; dma = dx; dmi = dy;
    end else begin
      ma0 = y_start; mi0 = x_start; ma1 = y_end; dma = dy; dmi = dx;
    end
    // run from the lower endpoint on the major axis
    if (dma[lr_pkg::DELTA_BITS-1]) begin
      ma1 = ma0;
      ma0 = x_major ? x_end : y_end;
      mi0 = x_major ? y_end : x_end;
      dma = -dma;
      dmi = -dmi;
    end
    line.major_pos   = ma0;
    line.minor_pos   = mi0;
    line.major_stop  = ma1;
    line.major_delta = dma;
    line.minor_delta = dmi;
    line.x_is_major  = x_major;
  end

endmodule

### design/lr_step.sv
// one bresenham step: major increment, error update, minor correction
// depends on lr_pkg

module lr_step (
  input  lr_pkg::lr_line_t                   line,
  input  logic signed [lr_pkg::ERR_BITS-1:0] error_term,
  output lr_pkg::lr_step_t                   step
);

  localparam int CW = lr_pkg::COORD_BITS;
  localparam int DW = lr_pkg::DELTA_BITS;
  localparam int EW = lr_pkg::ERR_BITS;

  logic [CW:0]            next_pos;
  logic signed [EW:0]     e1, e3;
  logic signed [EW+1:0]   e2, mdl;

  always_comb begin
    next_pos = {1'b0, line.major_pos} + {{CW{1'b0}}, 1'b1};
    e1  = {error_term[EW-1], error_term}
        - {{(EW+1-DW){line.minor_delta[DW-1]}}, line.minor_delta};
    e2  = {e1, 1'b0};
    mdl = $signed({{(EW+2-DW){1'b0}}, line.major_delta});
    step.done      = (next_pos >= {1'b0, line.major_stop});
    step.major_pos = next_pos[CW-1:0];
    step.minor_pos = line.minor_pos;
    e3             = e1;
    if (e2 < -mdl) begin
      step.minor_pos = line.minor_pos + {{(CW-1){1'b0}}, 1'b1};
      e3             = e1 + mdl[EW:0];
    end else if (e2 > mdl) begin
      step.minor_pos = line.minor_pos - {{(CW-1){1'b0}}, 1'b1};
      e3             = e1 - mdl[EW:0];
    end
    step.error_term = e3[EW-1:0];
  end

endmodule

### design/line_rasterizer_core.sv
// top level of the bresenham line rasterizer: line state and result register
// depends on lr_pkg, lr_setup and lr_step
//
// usage
//   input channel (in_valid/in_ready) carries one word per command:
//   in_opcode OP_LOAD loads the endpoints and returns the first given
//   endpoint; OP_STEP returns the next pixel of the line, and the final
//   step returns the second given endpoint with out_pixel_last set.
//   a step with no line active returns a word with every field zero
//   a load while a line is drawing drops the old line
//   result channel (out_valid/out_ready) returns exactly one word per
//   accepted input word, in order
//   out_valid rises in the cycle after an input word is accepted
//   throughput: one word per cycle while out_ready is high; the line state
//   is updated by increment, error update, three compares and minor-axis
//   correction; the result register frees itself in the cycle it is taken
//   stall: while a result waits untaken, in_ready stays low; in_ready
//   is high whenever the result register is empty or being taken
//   reset: synchronous active low; no line active, result register empty

module line_rasterizer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [lr_pkg::COORD_BITS-1:0] in_x_start,
  input  logic [lr_pkg::COORD_BITS-1:0] in_y_start,
  input  logic [lr_pkg::COORD_BITS-1:0] in_x_end,
  input  logic [lr_pkg::COORD_BITS-1:0] in_y_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lr_pkg::COORD_BITS-1:0] out_pixel_x,
  output logic [lr_pkg::COORD_BITS-1:0] out_pixel_y,
  output logic                          out_pixel_valid,
  output logic                          out_pixel_last
);

  localparam int CW = lr_pkg::COORD_BITS;

  // line state
  lr_pkg::lr_phase_t                  phase_r, phase_nxt;
  lr_pkg::lr_line_t                   line_r, line_nxt;
  logic signed [lr_pkg::ERR_BITS-1:0] err_r, err_nxt;
  logic [CW-1:0]                      final_x_r, final_x_nxt;
  logic [CW-1:0]                      final_y_r, final_y_nxt;

  // result register
  logic          out_valid_r;
  logic [CW-1:0] pix_x_r, pix_x_nxt;
  logic [CW-1:0] pix_y_r, pix_y_nxt;
  logic          pix_v_r, pix_v_nxt;
  logic          pix_l_r, pix_l_nxt;

  logic             accept;
  logic             drawing;
  lr_pkg::lr_line_t load_line;
  lr_pkg::lr_step_t step;

  lr_setup u_setup (
    .x_start (in_x_start),
    .y_start (in_y_start),
    .x_end   (in_x_end),
    .y_end   (in_y_end),
    .line    (load_line)
  );

  lr_step u_step (
    .line       (line_r),
    .error_term (err_r),
    .step       (step)
  );

  // result register frees itself when taken
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign drawing  = (phase_r == lr_pkg::PH_DRAW);

  // next line state
  always_comb begin
    phase_nxt   = phase_r;
    line_nxt    = line_r;
    err_nxt     = err_r;
    final_x_nxt = final_x_r;
    final_y_nxt = final_y_r;
    if (accept) begin
      unique case (in_opcode)
        lr_pkg::OP_LOAD: begin
          phase_nxt   = lr_pkg::PH_DRAW;
          line_nxt    = load_line;
          err_nxt     = '0;
          final_x_nxt = in_x_end;
          final_y_nxt = in_y_end;
        end
        lr_pkg::OP_STEP: begin
          if (drawing) begin
            if (step.done) begin
              phase_nxt = lr_pkg::PH_IDLE;
            end else begin
              line_nxt.major_pos = step.major_pos;
              line_nxt.minor_pos = step.minor_pos;
              err_nxt            = step.error_term;
            end
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // result word for the accepted input
  always_comb begin
    pix_x_nxt = '0;
    pix_y_nxt = '0;
    pix_v_nxt = 1'b0;
    pix_l_nxt = 1'b0;
    priority if (in_opcode == lr_pkg::OP_LOAD) begin
      // first given endpoint, never last
      pix_x_nxt = in_x_start;
      pix_y_nxt = in_y_start;
      pix_v_nxt = 1'b1;
    end else if (!drawing) begin
      // no line active: all-zero word
      pix_v_nxt = 1'b0;
    end else if (step.done) begin
      // closing endpoint as given
      pix_x_nxt = final_x_r;
      pix_y_nxt = final_y_r;
      pix_v_nxt = 1'b1;
      pix_l_nxt = 1'b1;
    end else begin
      pix_x_nxt = line_r.x_is_major ? step.major_pos : step.minor_pos;
      pix_y_nxt = line_r.x_is_major ? step.minor_pos : step.major_pos;
      pix_v_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lr_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line and result payload
  always_ff @(posedge clk) begin
    line_r    <= line_nxt;
    err_r     <= err_nxt;
    final_x_r <= final_x_nxt;
    final_y_r <= final_y_nxt;
    if (accept) begin
      pix_x_r <= pix_x_nxt;
      pix_y_r <= pix_y_nxt;
      pix_v_r <= pix_v_nxt;
      pix_l_r <= pix_l_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = pix_x_r;
  assign out_pixel_y     = pix_y_r;
  assign out_pixel_valid = pix_v_r;
  assign out_pixel_last  = pix_l_r;

endmodule

### design/lr_checker.sv
// port-level checks for the line rasterizer, bound to the top level
// depends on lr_pkg and line_rasterizer_core

module lr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lr_pkg::COORD_BITS-1:0] out_pixel_x,
  input logic [lr_pkg::COORD_BITS-1:0] out_pixel_y,
  input logic                          out_pixel_valid,
  input logic                          out_pixel_last
);

  // every accepted word gives a result word in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // a waiting result is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // last flag only on a drawn pixel
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_last |-> out_pixel_valid)
    else $error("last flag on an empty word");

  // empty word carries zero coordinates
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pixel_valid |-> (out_pixel_x == '0) && (out_pixel_y == '0))
    else $error("empty word with nonzero coordinates");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x)
      && $stable(out_pixel_y) && $stable(out_pixel_valid) && $stable(out_pixel_last))
    else $error("stalled result changed");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_pixel_x     (out_pixel_x),
  .out_pixel_y     (out_pixel_y),
  .out_pixel_valid (out_pixel_valid),
  .out_pixel_last  (out_pixel_last)
);

### tb/tb.sv
`timescale 1ns / 100ps
// testbench for line_rasterizer_core: directed corner lines, then random lines
// checked word by word against a behavioral bresenham tracker; needs lr_pkg

module tb;

  typedef logic [lr_pkg::COORD_BITS-1:0] coord_t;

  // one result word as the block returns it
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   valid;
    logic   last;
  } pixel_t;

  localparam coord_t COORD_MAX = '1;

  logic   clk             = 1'b0;
  logic   rst_n           = 1'b0;
  logic   in_valid        = 1'b0;
  logic   in_ready;
  logic   in_opcode       = lr_pkg::OP_LOAD;
  coord_t in_x_start      = '0;
  coord_t in_y_start      = '0;
  coord_t in_x_end        = '0;
  coord_t in_y_end        = '0;
  logic   out_valid;
  logic   out_ready       = 1'b0;
  coord_t out_pixel_x;
  coord_t out_pixel_y;
  logic   out_pixel_valid;
  logic   out_pixel_last;

  line_rasterizer_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_last  (out_pixel_last)
  );

  // line tracker: the walk along the major axis, kept in step with the block
  coord_t            ln_major      = '0;
  coord_t            ln_minor      = '0;
  coord_t            ln_stop       = '0;
  coord_t            ln_final_x    = '0;
  coord_t            ln_final_y    = '0;
  int                ln_major_span = 0;
  int                ln_minor_span = 0;
  int                ln_err        = 0;
  bit                ln_x_major    = 1'b0;
  lr_pkg::lr_phase_t ln_phase      = lr_pkg::PH_IDLE;

  pixel_t pending_pixels[$];

  bit idle_on        = 1'b1;
  int words_sent     = 0;
  int lines_loaded   = 0;
  int lines_closed   = 0;
  int pixels_checked = 0;
  int fail_count     = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // works out the word the block owes for one accepted command
  function automatic pixel_t next_pixel(logic op, coord_t xs, coord_t ys,
                                        coord_t xe, coord_t ye);
    int     dx, dy, dma, dmi, nxt;
    coord_t ma0, mi0, ma1;
    pixel_t px;
    px = '0;
    if (op == lr_pkg::OP_LOAD) begin
      dx = int'(xe) - int'(xs);
      dy = int'(ye) - int'(ys);
      // equal spans go x-major, so exact diagonals draw along x
      ln_x_major = ((dx < 0 ? -dx : dx) >= (dy < 0 ? -dy : dy));
      if (ln_x_major) begin
        ma0 = xs; mi0 = ys; ma1 = xe; dma = dx; dmi = dy;
      end else begin
        ma0 = ys; mi0 = xs; ma1 = ye; dma = dy; dmi = dx;
      end
      // walk upward along the major axis: start from the other endpoint
      if (dma < 0) begin
        ma1 = ma0;
        ma0 = ln_x_major ? xe : ye;
        mi0 = ln_x_major ? ye : xe;
        dma = -dma;
        dmi = -dmi;
      end
      ln_major      = ma0;
      ln_minor      = mi0;
      ln_stop       = ma1;
      ln_major_span = dma;
      ln_minor_span = dmi;
      ln_err        = 0;
      ln_final_x    = xe;
      ln_final_y    = ye;
      ln_phase      = lr_pkg::PH_DRAW;
      px.x     = xs;
      px.y     = ys;
      px.valid = 1'b1;
    end else if (ln_phase == lr_pkg::PH_DRAW) begin
      nxt = int'(ln_major) + 1;
      if (nxt >= int'(ln_stop)) begin
        // closing word is always the second given endpoint
        ln_phase = lr_pkg::PH_IDLE;
        px.x     = ln_final_x;
        px.y     = ln_final_y;
        px.valid = 1'b1;
        px.last  = 1'b1;
      end else begin
        ln_major = coord_t'(nxt);
        ln_err   = ln_err - ln_minor_span;
        if (2 * ln_err < -ln_major_span) begin
          ln_minor = ln_minor + coord_t'(1);
          ln_err   = ln_err + ln_major_span;
        end else if (2 * ln_err > ln_major_span) begin
          ln_minor = ln_minor - coord_t'(1);
          ln_err   = ln_err - ln_major_span;
        end
        px.valid = 1'b1;
        if (ln_x_major) begin
          px.x = ln_major;
          px.y = ln_minor;
        end else begin
          px.x = ln_minor;
          px.y = ln_major;
        end
      end
    end
    return px;
  endfunction

  // coordinates biased toward the edges of the grid
  function automatic coord_t pick_coord();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return COORD_MAX;
    return coord_t'($urandom);
  endfunction

  // drive one command word and hold it until the block takes it
  task automatic send_word(logic op, coord_t xs, coord_t ys, coord_t xe, coord_t ye);
    @(negedge clk);
    if (idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_x_start <= xs;
    in_y_start <= ys;
    in_x_end   <= xe;
    in_y_end   <= ye;
    do @(posedge clk); while (!in_ready);
    pending_pixels.push_back(next_pixel(op, xs, ys, xe, ye));
    words_sent++;
    if (op == lr_pkg::OP_LOAD) lines_loaded++;
  endtask

  // step word: coordinate fields are don't-care, so toggle them freely
  task automatic send_step();
    send_word(lr_pkg::OP_STEP, coord_t'($urandom), coord_t'($urandom),
              coord_t'($urandom), coord_t'($urandom));
  endtask

  // drop valid and hold off until every owed word is back
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // corner cases: idle step, single point, span of one, diagonal, reload
  // while drawing, steep and reversed lines, coordinates at both extremes
  task automatic test_directed();
    int i;
    send_word(lr_pkg::OP_STEP, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_word(lr_pkg::OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_step();
    send_step();
    send_word(lr_pkg::OP_LOAD, 12'd10, 12'd20, 12'd11, 12'd20);
    send_step();
    send_word(lr_pkg::OP_LOAD, '0, '0, COORD_MAX, COORD_MAX);
    send_step();
    send_step();
    send_word(lr_pkg::OP_LOAD, COORD_MAX, '0, 12'd4092, 12'd3);
    for (i = 0; i < 3; i++) send_step();
    send_word(lr_pkg::OP_LOAD, 12'd5, 12'd9, 12'd5, 12'd6);
    for (i = 0; i < 3; i++) send_step();
    send_word(lr_pkg::OP_LOAD, '0, COORD_MAX, 12'd2, 12'd4089);
    for (i = 0; i < 6; i++) send_step();
  endtask

  // mostly complete lines with random endpoints, some dropped early or
  // overrun, mixed with arbitrary words
  task automatic run_random_lines(int quota);
    int stop_at, span, dx, dy, xs, ys, xe, ye;
    stop_at = words_sent + quota;
    while (words_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_word(logic'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom));
      end else begin
        span = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(16);
        xs = pick_coord();
        ys = pick_coord();
        dx = int'($urandom_range(2 * span)) - span;
        dy = int'($urandom_range(2 * span)) - span;
        xe = xs + dx;
        ye = ys + dy;
        // reflect ends that fall off the grid
        if (xe < 0 || xe > int'(COORD_MAX)) xe = xs - dx;
        if (ye < 0 || ye > int'(COORD_MAX)) ye = ys - dy;
        send_word(lr_pkg::OP_LOAD, coord_t'(xs), coord_t'(ys), coord_t'(xe), coord_t'(ye));
        while (ln_phase == lr_pkg::PH_DRAW && $urandom_range(59) != 0) send_step();
        if ($urandom_range(4) == 0) send_step();
      end
    end
  endtask

  task automatic test_random_stalled(int quota);
    idle_on = 1'b1;
    run_random_lines(quota);
  endtask

  // sender stops mid-stream until the result side has caught up
  task automatic test_hold_until_drained(int quota);
    idle_on = 1'b1;
    run_random_lines(quota / 2);
    drain_pixels();
    run_random_lines(quota - quota / 2);
  endtask

  // back to back words, receiver always ready
  task automatic test_streaming(int quota);
    idle_on = 1'b0;
    run_random_lines(quota);
    drain_pixels();
    idle_on = 1'b1;
  endtask

  // receiver stalls at random while idling is on
  always @(negedge clk) begin
    out_ready <= idle_on ? ($urandom_range(99) >= 32) : 1'b1;
  end

  function automatic void check_field(string what, int want_v, int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
      fail_count++;
    end
  endfunction

  // every taken result word against the oldest owed word
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: result word with none owed, x %0d y %0d valid %0b last %0b",
                 $time, out_pixel_x, out_pixel_y, out_pixel_valid, out_pixel_last);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("pixel_x", want.x, out_pixel_x);
        check_field("pixel_y", want.y, out_pixel_y);
        check_field("pixel_valid", want.valid, out_pixel_valid);
        check_field("pixel_last", want.last, out_pixel_last);
        pixels_checked++;
        if (want.last) lines_closed++;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    drain_pixels();
    test_random_stalled(500);
    test_hold_until_drained(400);
    drain_pixels();
    test_streaming(300);
    test_random_stalled(200);
    drain_pixels();

    $display("ran %0d command words, %0d line loads, %0d lines drawn to the end",
             words_sent, lines_loaded, lines_closed);
    $display("checked %0d result words with stalls, a full drain and a no-idle stretch",
             pixels_checked);
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #3000000;
    $display("timeout with %0d words still owed", pending_pixels.size());
    $display("Verification failed");
    $finish;
  end

endmodule
